// ===== rtl/core/aaline_pkg.sv =====
// Shared types, codes and helpers for the antialiased line rasterizer.
package aaline_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF    = 10;
  localparam int FRACTION_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE_COLOR     = 2'd0;
  localparam logic [1:0] CFG_INTENSITY_BITS = 2'd1;

  // Reset values of the configuration registers
  localparam logic [7:0] BASE_COLOR_RST     = 8'd0;
  localparam logic [3:0] INTENSITY_BITS_RST = 4'd4;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Line classification
  typedef enum logic [2:0] {
    KIND_POINT = 3'd0,
    KIND_HORIZ = 3'd1,
    KIND_VERT  = 3'd2,
    KIND_DIAG  = 3'd3,
    KIND_YMAJ  = 3'd4,
    KIND_XMAJ  = 3'd5
  } line_kind_t;

  // Sequencer states
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SORT     = 7'b0000010,
    ST_CLASSIFY = 7'b0000100,
    ST_DIVIDE   = 7'b0001000,
    ST_STEP     = 7'b0010000,
    ST_EMIT_A   = 7'b0100000,
    ST_EMIT_B   = 7'b1000000
  } seq_state_t;

  // Right shift that keeps the top intensity bits of an 8-bit window;
  // zero acts as one level bit and anything above eight acts as eight.
  function automatic logic [2:0] weight_shift(input logic [3:0] ibits);
    logic [3:0] eff;
    begin
      if (ibits == 4'd0) begin
        eff = 4'd1;
      end else if (ibits > 4'd8) begin
        eff = 4'd8;
      end else begin
        eff = ibits;
      end
      weight_shift = 3'(4'd8 - eff);
    end
  endfunction

endpackage

// ===== rtl/core/antialiased_line_fixed_rasterizer_unit.sv =====
// Antialiased line rasterizer with a shared restoring divider and a small sequencer.
//
// Channels: input items (op, start_x, start_y, end_x, end_y) transfer when
// in_valid is high and in_stall is low; result pixels (pixel_x, pixel_y,
// color_index, line_done, last) transfer when out_valid is high and out_stall
// is low. Registers base_color (index 0) and intensity_bits (index 1) are
// written over the cfg channel, which is always ready.
// A start item (op 0) passes through the sort and classify states; point,
// horizontal, vertical and diagonal lines then go to the output, while X- or
// Y-major lines first pass through the divide state, whose restoring divider
// resolves one quotient bit per cycle to form the step value; one pixel
// follows. A step item (op 1) gives a single pixel or a weighted pair: the
// step state updates the cursor and, for X- or Y-major lines, the error
// accumulator, then each pixel in turn is loaded into the output register.
// A step with no active line is dropped.
// One item is in flight at a time; in_stall stays high until all of its
// pixels have entered the output register.
// Reset clears the sequencer, the line state and the output valid, and sets
// base_color to 0 and intensity_bits to 4. While out_valid and out_stall are
// both high the output register holds its pixel and the sequencer waits to load the next one.
module antialiased_line_fixed_rasterizer_unit #(
  parameter int COORD_BITS    = aaline_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = aaline_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  // result pixels
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [7:0]            color_index,
  output logic                  line_done,
  output logic                  last,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data
);

  localparam int CW    = COORD_BITS;
  localparam int FW    = FRACTION_BITS;
  localparam int CNT_W = $clog2(FRACTION_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRACTION_BITS - 1);

  // configuration
  logic [7:0] base_color;
  logic [3:0] intensity_bits;

  // sequencer
  aaline_pkg::seq_state_t state;

  // captured endpoints
  logic [CW-1:0] raw_x0, raw_y0, raw_x1, raw_y1;

  // line state
  logic                   line_active;
  aaline_pkg::line_kind_t line_kind;
  logic [CW-1:0]          cursor_x, cursor_y, final_x, final_y;
  logic                   x_moves_left;
  logic [CW-1:0]          steps_left;
  logic [FW-1:0]          error_accumulator;
  logic [FW-1:0]          error_step;
  logic [CW-1:0]          delta_x, delta_y;

  // divider
  logic [CW-1:0]    div_rem;
  logic [CW-1:0]    div_major;
  logic [CNT_W-1:0] div_cnt;

  // pending pixels
  logic [CW-1:0] p0_x, p0_y, p1_x, p1_y;
  logic [7:0]    p0_color, p1_color;
  logic          p0_done, p0_last, pair;

  logic in_xfer, out_free, load_out;
  logic cfg_xfer;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign in_stall  = (state != aaline_pkg::ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = out_free &&
                     (state == aaline_pkg::ST_EMIT_A || state == aaline_pkg::ST_EMIT_B);

  // ---------------------------------------------------------------------------
  // Endpoint ordering (sort cycle)
  // ---------------------------------------------------------------------------
  logic          swap_ends;
  logic [CW-1:0] sx0, sy0, sx1, sy1, sdx, sdy;
  logic          sleft;

  always_comb begin
    swap_ends = raw_y0 > raw_y1;
    sx0   = swap_ends ? raw_x1 : raw_x0;
    sy0   = swap_ends ? raw_y1 : raw_y0;
    sx1   = swap_ends ? raw_x0 : raw_x1;
    sy1   = swap_ends ? raw_y0 : raw_y1;
    sleft = sx1 < sx0;
    sdx   = sleft ? (sx0 - sx1) : (sx1 - sx0);
    sdy   = sy1 - sy0;
  end

  // ---------------------------------------------------------------------------
  // Classification (classify cycle)
  // ---------------------------------------------------------------------------
  aaline_pkg::line_kind_t kind_c;
  logic [CW-1:0]          steps_c;
  logic                   y_major_c;

  always_comb begin
    y_major_c = delta_y > delta_x;
    if (delta_y == '0) begin
      kind_c  = (delta_x == '0) ? aaline_pkg::KIND_POINT : aaline_pkg::KIND_HORIZ;
      steps_c = delta_x;
    end else if (delta_x == '0) begin
      kind_c  = aaline_pkg::KIND_VERT;
      steps_c = delta_y;
    end else if (delta_x == delta_y) begin
      kind_c  = aaline_pkg::KIND_DIAG;
      steps_c = delta_y;
    end else if (y_major_c) begin
      kind_c  = aaline_pkg::KIND_YMAJ;
      steps_c = delta_y;
    end else begin
      kind_c  = aaline_pkg::KIND_XMAJ;
      steps_c = delta_x;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider: one restoring step per cycle
  // ---------------------------------------------------------------------------
  logic [CW:0]   div_shift;
  logic          div_ge;
  logic [CW:0]   div_diff;

  always_comb begin
    div_shift = {div_rem, 1'b0};
    div_ge    = div_shift >= {1'b0, div_major};
    div_diff  = div_shift - {1'b0, div_major};
  end

  // ---------------------------------------------------------------------------
  // Step datapath
  // ---------------------------------------------------------------------------
  logic [FW-1:0] acc_new;
  logic          minor_move;
  logic          is_major;
  logic [CW-1:0] x_adv, y_adv, nx, ny, px, py;
  logic [2:0]    wshift;
  logic [7:0]    wmask, weight;

  always_comb begin
    acc_new    = error_accumulator + error_step;
    minor_move = acc_new <= error_accumulator;
    is_major   = (line_kind == aaline_pkg::KIND_YMAJ) ||
                 (line_kind == aaline_pkg::KIND_XMAJ);
    x_adv      = x_moves_left ? (cursor_x - 1'b1) : (cursor_x + 1'b1);
    y_adv      = cursor_y + 1'b1;

    unique case (line_kind)
      aaline_pkg::KIND_YMAJ: begin
        nx = minor_move ? x_adv : cursor_x;
        ny = y_adv;
      end
      aaline_pkg::KIND_XMAJ: begin
        nx = x_adv;
        ny = minor_move ? y_adv : cursor_y;
      end
      aaline_pkg::KIND_HORIZ: begin
        nx = x_adv;
        ny = cursor_y;
      end
      aaline_pkg::KIND_VERT: begin
        nx = cursor_x;
        ny = y_adv;
      end
      aaline_pkg::KIND_DIAG: begin
        nx = x_adv;
        ny = y_adv;
      end
      default: begin
        nx = cursor_x;
        ny = cursor_y;
      end
    endcase

    // partner pixel sits one further along the minor axis
    if (line_kind == aaline_pkg::KIND_YMAJ) begin
      px = x_moves_left ? (nx - 1'b1) : (nx + 1'b1);
      py = ny;
    end else begin
      px = nx;
      py = ny + 1'b1;
    end

    wshift = aaline_pkg::weight_shift(intensity_bits);
    wmask  = 8'hFF >> wshift;
    weight = acc_new[FW-1 -: 8] >> wshift;
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_color     <= aaline_pkg::BASE_COLOR_RST;
      intensity_bits <= aaline_pkg::INTENSITY_BITS_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_index)
        aaline_pkg::CFG_BASE_COLOR:     base_color     <= cfg_data;
        aaline_pkg::CFG_INTENSITY_BITS: intensity_bits <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and line state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= aaline_pkg::ST_IDLE;
      line_active       <= 1'b0;
      line_kind         <= aaline_pkg::KIND_POINT;
      cursor_x          <= '0;
      cursor_y          <= '0;
      final_x           <= '0;
      final_y           <= '0;
      x_moves_left      <= 1'b0;
      steps_left        <= '0;
      error_accumulator <= '0;
      error_step        <= '0;
      pair              <= 1'b0;
      div_cnt           <= '0;
    end else begin
      unique case (state)
        aaline_pkg::ST_IDLE: begin
          // take an item; drop a step with no active line
          if (in_xfer) begin
            if (op == aaline_pkg::OP_START) begin
              state <= aaline_pkg::ST_SORT;
            end else if (line_active) begin
              state <= aaline_pkg::ST_STEP;
            end
          end
        end
        aaline_pkg::ST_SORT: begin
          cursor_x          <= sx0;
          cursor_y          <= sy0;
          final_x           <= sx1;
          final_y           <= sy1;
          x_moves_left      <= sleft;
          error_accumulator <= '0;
          error_step        <= '0;
          state             <= aaline_pkg::ST_CLASSIFY;
        end
        aaline_pkg::ST_CLASSIFY: begin
          line_kind   <= kind_c;
          steps_left  <= steps_c;
          line_active <= (steps_c != '0);
          pair        <= 1'b0;
          div_cnt     <= '0;
          if (kind_c == aaline_pkg::KIND_YMAJ || kind_c == aaline_pkg::KIND_XMAJ) begin
            state <= aaline_pkg::ST_DIVIDE;
          end else begin
            state <= aaline_pkg::ST_EMIT_A;
          end
        end
        aaline_pkg::ST_DIVIDE: begin
          // shift one quotient bit into the step value
          error_step <= {error_step[FW-2:0], div_ge};
          div_cnt    <= div_cnt + 1'b1;
          if (div_cnt == CNT_LAST) begin
            state <= aaline_pkg::ST_EMIT_A;
          end
        end
        aaline_pkg::ST_STEP: begin
          if (is_major) begin
            if (steps_left <= CW'(1)) begin
              // final endpoint alone at full intensity
              steps_left  <= '0;
              line_active <= 1'b0;
              cursor_x    <= final_x;
              cursor_y    <= final_y;
              pair        <= 1'b0;
            end else begin
              steps_left        <= steps_left - 1'b1;
              error_accumulator <= acc_new;
              cursor_x          <= nx;
              cursor_y          <= ny;
              pair              <= 1'b1;
            end
          end else begin
            cursor_x <= nx;
            cursor_y <= ny;
            pair     <= 1'b0;
            if (steps_left != '0) begin
              steps_left <= steps_left - 1'b1;
            end
            if (steps_left <= CW'(1)) begin
              line_active <= 1'b0;
            end
          end
          state <= aaline_pkg::ST_EMIT_A;
        end
        aaline_pkg::ST_EMIT_A: begin
          if (out_free) begin
            state <= pair ? aaline_pkg::ST_EMIT_B : aaline_pkg::ST_IDLE;
          end
        end
        aaline_pkg::ST_EMIT_B: begin
          if (out_free) begin
            state <= aaline_pkg::ST_IDLE;
          end
        end
        default: state <= aaline_pkg::ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers: endpoints, divider operands, pending pixels
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer && op == aaline_pkg::OP_START) begin
      raw_x0 <= start_x;
      raw_y0 <= start_y;
      raw_x1 <= end_x;
      raw_y1 <= end_y;
    end
    if (state == aaline_pkg::ST_SORT) begin
      delta_x <= sdx;
      delta_y <= sdy;
    end
    unique case (state)
      aaline_pkg::ST_CLASSIFY: begin
        div_major <= y_major_c ? delta_y : delta_x;
        div_rem   <= y_major_c ? delta_x : delta_y;
        p0_x      <= cursor_x;
        p0_y      <= cursor_y;
        p0_color  <= base_color;
        p0_done   <= (steps_c == '0);
        p0_last   <= 1'b1;
      end
      aaline_pkg::ST_DIVIDE: begin
        div_rem <= div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
      end
      aaline_pkg::ST_STEP: begin
        p1_x     <= px;
        p1_y     <= py;
        p1_color <= base_color + (weight ^ wmask);
        if (is_major && steps_left <= CW'(1)) begin
          p0_x     <= final_x;
          p0_y     <= final_y;
          p0_color <= base_color;
          p0_done  <= 1'b1;
          p0_last  <= 1'b1;
        end else if (is_major) begin
          p0_x     <= nx;
          p0_y     <= ny;
          p0_color <= base_color + weight;
          p0_done  <= 1'b0;
          p0_last  <= 1'b0;
        end else begin
          p0_x     <= nx;
          p0_y     <= ny;
          p0_color <= base_color;
          p0_done  <= (steps_left <= CW'(1));
          p0_last  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state == aaline_pkg::ST_EMIT_A) begin
        pixel_x     <= p0_x;
        pixel_y     <= p0_y;
        color_index <= p0_color;
        line_done   <= p0_done;
        last        <= p0_last;
      end else begin
        pixel_x     <= p1_x;
        pixel_y     <= p1_y;
        color_index <= p1_color;
        line_done   <= 1'b0;
        last        <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_active_has_steps: assert property (@(posedge clk) disable iff (rst)
    line_active |-> steps_left != '0)
    else $error("active line with no steps left");

  a_divide_major_only: assert property (@(posedge clk) disable iff (rst)
    state == aaline_pkg::ST_DIVIDE |->
      (line_kind == aaline_pkg::KIND_YMAJ || line_kind == aaline_pkg::KIND_XMAJ))
    else $error("divider running for a line that needs no step value");

  a_divide_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == aaline_pkg::ST_DIVIDE |-> div_rem < div_major)
    else $error("divider remainder not below divisor");

  a_step_needs_line: assert property (@(posedge clk) disable iff (rst)
    state == aaline_pkg::ST_STEP |-> line_active)
    else $error("step taken with no active line");

  a_start_sorts: assert property (@(posedge clk) disable iff (rst)
    in_xfer && op == aaline_pkg::OP_START |=> state == aaline_pkg::ST_SORT)
    else $error("start item did not enter the sort cycle");

endmodule
